// ===== rtl/rle_pkg.sv =====
// shared constants, byte select codes and controller/datapath structs
// for the run/raw packet encoder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rle_pkg;

  localparam int unsigned MAX_PACKET = 126;
  localparam int unsigned MIN_RUN    = 3;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LANES      = 8;
  localparam int unsigned WORD_W     = LANES * BYTE_W;
  localparam int unsigned BCNT_W     = 4;

  localparam logic [BYTE_W-1:0] RUN_FLAG = 8'h80;

  // source of the byte pushed into the output packer
  typedef enum logic [1:0] {
    SEL_RAW_HDR,
    SEL_RAW_DATA,
    SEL_RUN_HDR,
    SEL_RUN_VAL
  } byte_sel_e;

  typedef struct packed {
    logic      accept;
    logic      extend;
    logic      load_new;
    logic      push;
    byte_sel_e sel;
    logic      rd_start;
    logic      rd_next;
    logic      raw_clear;
    logic      append;
    logic      run_clear;
    logic      finish;
  } rle_cmd_t;

  typedef struct packed {
    logic match;
    logic in_last;
    logic run_zero;
    logic run_long;
    logic run_one;
    logic raw_empty;
    logic raw_over;
    logic rd_done;
    logic push_ok;
    logic finish_ok;
    logic last;
  } rle_sts_t;

endpackage

`default_nettype wire

// ===== rtl/rle_packet_encoder_top.sv =====
// top level of the run/raw packet encoder: controller plus datapath
// depends on rle_pkg, rle_ctrl, rle_dpath
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake               payload
// input     in         in_valid_i/in_stall_o   data_byte_i, stream_last_i
// output    out        out_valid_o/out_stall_i out_bytes_o, byte_count_o,
//                                              burst_end_o, stream_end_o
//
// a byte that extends the open piece but is not the last is done in the idle state;
// any other byte also takes sequencing and store appends plus one push per packer byte
// (raw header, each stored raw byte over the single store read port, run header/value)
// one input transfer at a time; the next is taken once its last word is in the output reg
// rst_ni clears the open piece, the raw count and the packer; the store is never read unwritten
// a stalled output holds the packer only when a ninth byte or the finish needs the output reg

module rle_packet_encoder_top #(
  parameter int unsigned MaxPacket = rle_pkg::MAX_PACKET,
  parameter int unsigned MinRun    = rle_pkg::MIN_RUN
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rle_pkg::BYTE_W-1:0]  data_byte_i,
  input  wire logic                        stream_last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [rle_pkg::WORD_W-1:0]       out_bytes_o,
  output logic [rle_pkg::BCNT_W-1:0]       byte_count_o,
  output logic                             burst_end_o,
  output logic                             stream_end_o
);

  // commands from the sequencer, status back from the datapath
  rle_pkg::rle_cmd_t cmd;
  rle_pkg::rle_sts_t sts;

  // sequencer: closes pieces, flushes raw packets, finishes each transfer
  rle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: piece registers, raw store, byte packer, output register
  rle_dpath #(
    .MaxPacket (MaxPacket),
    .MinRun    (MinRun)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .stream_last_i (stream_last_i),
    .out_stall_i   (out_stall_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_bytes_o   (out_bytes_o),
    .byte_count_o  (byte_count_o),
    .burst_end_o   (burst_end_o),
    .stream_end_o  (stream_end_o)
  );

endmodule

`default_nettype wire

// ===== rtl/rle_ctrl.sv =====
// sequencing state machine of the run/raw packet encoder
// depends on rle_pkg (command and status structs)
`timescale 1ns / 1ps
`default_nettype none

module rle_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire rle_pkg::rle_sts_t sts_i,
  output rle_pkg::rle_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLOSE,
    S_FLUSH_HDR,
    S_FLUSH_DATA,
    S_RUN_HDR,
    S_RUN_VAL,
    S_APPEND,
    S_NEXT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  state_e ret_q, ret_d;
  logic   phase_q, phase_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    ret_d   = ret_q;
    phase_d = phase_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          phase_d      = 1'b0;
          if (sts_i.match) begin
            cmd_o.extend = 1'b1;
            if (sts_i.in_last) begin
              phase_d = 1'b1;
              state_d = S_CLOSE;
            end
          end else begin
            state_d = S_CLOSE;
          end
        end
      end
      S_CLOSE: begin
        if (sts_i.run_zero) begin
          state_d = S_NEXT;
        end else if (sts_i.run_long) begin
          ret_d   = S_RUN_HDR;
          state_d = sts_i.raw_empty ? S_RUN_HDR : S_FLUSH_HDR;
        end else begin
          ret_d   = S_APPEND;
          state_d = sts_i.raw_over ? S_FLUSH_HDR : S_APPEND;
        end
      end
      S_FLUSH_HDR: begin
        if (sts_i.push_ok) begin
          cmd_o.push     = 1'b1;
          cmd_o.sel      = rle_pkg::SEL_RAW_HDR;
          cmd_o.rd_start = 1'b1;
          state_d        = S_FLUSH_DATA;
        end
      end
      S_FLUSH_DATA: begin
        if (sts_i.push_ok) begin
          cmd_o.push    = 1'b1;
          cmd_o.sel     = rle_pkg::SEL_RAW_DATA;
          cmd_o.rd_next = 1'b1;
          if (sts_i.rd_done) begin
            cmd_o.raw_clear = 1'b1;
            state_d         = ret_q;
          end
        end
      end
      S_RUN_HDR: begin
        if (sts_i.push_ok) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = rle_pkg::SEL_RUN_HDR;
          state_d    = S_RUN_VAL;
        end
      end
      S_RUN_VAL: begin
        if (sts_i.push_ok) begin
          cmd_o.push      = 1'b1;
          cmd_o.sel       = rle_pkg::SEL_RUN_VAL;
          cmd_o.run_clear = 1'b1;
          state_d         = S_NEXT;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        if (sts_i.run_one) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!phase_q) begin
          cmd_o.load_new = 1'b1;
          if (sts_i.last) begin
            phase_d = 1'b1;
            state_d = S_CLOSE;
          end else begin
            state_d = S_FINISH;
          end
        end else if (sts_i.raw_empty) begin
          state_d = S_FINISH;
        end else begin
          ret_d   = S_FINISH;
          state_d = S_FLUSH_HDR;
        end
      end
      S_FINISH: begin
        if (sts_i.finish_ok) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_q      <= S_FINISH;
      phase_q    <= 1'b0;
      in_stall_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      phase_q    <= phase_d;
      in_stall_o <= (state_d != S_IDLE);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rle_dpath.sv =====
// datapath of the run/raw packet encoder: open piece, raw byte store,
// byte packer and output register; depends on rle_pkg
`timescale 1ns / 1ps
`default_nettype none

module rle_dpath #(
  parameter int unsigned MaxPacket = rle_pkg::MAX_PACKET,
  parameter int unsigned MinRun    = rle_pkg::MIN_RUN
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [rle_pkg::BYTE_W-1:0]  data_byte_i,
  input  wire logic                        stream_last_i,
  input  wire logic                        out_stall_i,
  input  wire rle_pkg::rle_cmd_t           cmd_i,
  output rle_pkg::rle_sts_t                sts_o,
  output logic                             out_valid_o,
  output logic [rle_pkg::WORD_W-1:0]       out_bytes_o,
  output logic [rle_pkg::BCNT_W-1:0]       byte_count_o,
  output logic                             burst_end_o,
  output logic                             stream_end_o
);

  localparam int unsigned LenW  = $clog2(MaxPacket + 1);
  localparam int unsigned SumW  = LenW + 1;
  localparam int unsigned IdxW  = $clog2(MaxPacket);
  localparam int unsigned LaneW = $clog2(rle_pkg::LANES);
  localparam logic [rle_pkg::BCNT_W-1:0] FullCnt = rle_pkg::BCNT_W'(rle_pkg::LANES);

  logic [rle_pkg::BYTE_W-1:0] byte_q;
  logic                       last_q;
  logic [rle_pkg::BYTE_W-1:0] run_val_q;
  logic [LenW-1:0]            run_len_q;
  logic [LenW-1:0]            raw_cnt_q;
  logic [LenW-1:0]            rd_ptr_q;
  logic [rle_pkg::BYTE_W-1:0] rdata_q;
  logic [rle_pkg::BYTE_W-1:0] raw_mem [MaxPacket];
  logic [IdxW-1:0]            rd_addr;
  logic                       rd_en;

  logic [rle_pkg::LANES-1:0][rle_pkg::BYTE_W-1:0] acc_q;
  logic [rle_pkg::BCNT_W-1:0] pk_cnt_q;
  logic [rle_pkg::BYTE_W-1:0] push_byte;
  logic                       pk_full;
  logic                       out_free;
  logic                       out_load;
  logic [SumW-1:0]            raw_sum;

  logic                       out_valid_q;
  logic [rle_pkg::WORD_W-1:0] out_bytes_q;
  logic [rle_pkg::BCNT_W-1:0] out_cnt_q;
  logic                       burst_q;
  logic                       stream_q;

  // status
  assign raw_sum  = {1'b0, raw_cnt_q} + {1'b0, run_len_q};
  assign pk_full  = (pk_cnt_q == FullCnt);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o           = '0;
    sts_o.match     = (run_len_q != '0) && (data_byte_i == run_val_q)
                      && (run_len_q < LenW'(MaxPacket));
    sts_o.in_last   = stream_last_i;
    sts_o.run_zero  = (run_len_q == '0);
    sts_o.run_long  = (run_len_q >= LenW'(MinRun));
    sts_o.run_one   = (run_len_q == LenW'(1));
    sts_o.raw_empty = (raw_cnt_q == '0);
    sts_o.raw_over  = (raw_sum > SumW'(MaxPacket));
    sts_o.rd_done   = (rd_ptr_q == raw_cnt_q);
    sts_o.push_ok   = !pk_full || out_free;
    sts_o.finish_ok = (pk_cnt_q == '0) || out_free;
    sts_o.last      = last_q;
  end

  // open piece and raw store bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= 1'b0;
      run_val_q <= '0;
      run_len_q <= '0;
      raw_cnt_q <= '0;
      rd_ptr_q  <= '0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= stream_last_i;
      end
      if (cmd_i.extend) begin
        run_len_q <= run_len_q + LenW'(1);
      end else if (cmd_i.load_new) begin
        run_val_q <= byte_q;
        run_len_q <= LenW'(1);
      end else if (cmd_i.run_clear) begin
        run_len_q <= '0;
      end else if (cmd_i.append) begin
        run_len_q <= run_len_q - LenW'(1);
      end
      if (cmd_i.append) begin
        raw_cnt_q <= raw_cnt_q + LenW'(1);
      end else if (cmd_i.raw_clear) begin
        raw_cnt_q <= '0;
      end
      if (cmd_i.rd_start) begin
        rd_ptr_q <= LenW'(1);
      end else if (cmd_i.rd_next) begin
        rd_ptr_q <= rd_ptr_q + LenW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= data_byte_i;
    end
  end

  // raw store: one write port, one registered read port
  assign rd_addr = cmd_i.rd_start ? '0 : rd_ptr_q[IdxW-1:0];
  assign rd_en   = cmd_i.rd_start || (cmd_i.rd_next && (rd_ptr_q < raw_cnt_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.append) begin
      raw_mem[raw_cnt_q[IdxW-1:0]] <= run_val_q;
    end
    if (rd_en) begin
      rdata_q <= raw_mem[rd_addr];
    end
  end

  // byte select
  always_comb begin
    case (cmd_i.sel)
      rle_pkg::SEL_RAW_HDR:  push_byte = rle_pkg::BYTE_W'(raw_cnt_q - LenW'(1));
      rle_pkg::SEL_RAW_DATA: push_byte = rdata_q;
      rle_pkg::SEL_RUN_HDR:  push_byte = rle_pkg::RUN_FLAG
                                         | rle_pkg::BYTE_W'(run_len_q - LenW'(1));
      rle_pkg::SEL_RUN_VAL:  push_byte = run_val_q;
      default:               push_byte = run_val_q;
    endcase
  end

  // packer: a full word waits until the next byte or the finish
  assign out_load = (cmd_i.push && pk_full) || (cmd_i.finish && (pk_cnt_q != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      pk_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.push) begin
        if (pk_full) begin
          acc_q    <= rle_pkg::WORD_W'(push_byte);
          pk_cnt_q <= rle_pkg::BCNT_W'(1);
        end else begin
          acc_q[pk_cnt_q[LaneW-1:0]] <= push_byte;
          pk_cnt_q <= pk_cnt_q + rle_pkg::BCNT_W'(1);
        end
      end else if (cmd_i.finish) begin
        acc_q    <= '0;
        pk_cnt_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bytes_q <= acc_q;
      out_cnt_q   <= pk_cnt_q;
      burst_q     <= cmd_i.finish;
      stream_q    <= cmd_i.finish && last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_bytes_o  = out_bytes_q;
  assign byte_count_o = out_cnt_q;
  assign burst_end_o  = burst_q;
  assign stream_end_o = stream_q;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// self-checking testbench for rle_packet_encoder_top: drives byte streams over
// the valid/stall input channel and checks every packed output word
// depends on rtl/rle_pkg.sv and rtl/rle_packet_encoder_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_LIMIT  = 5000;
  localparam int unsigned SETTLE       = 32;
  localparam int unsigned END_TAIL     = 64;
  localparam int unsigned SINK_HOLD    = 400;

  // one expected output transfer
  typedef struct packed {
    logic [rle_pkg::WORD_W-1:0] word;
    logic [rle_pkg::BCNT_W-1:0] count;
    logic                       burst_end;
    logic                       stream_end;
  } packed_word_t;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [rle_pkg::BYTE_W-1:0] data_byte_i   = '0;
  logic                       stream_last_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic [rle_pkg::WORD_W-1:0] out_bytes_o;
  logic [rle_pkg::BCNT_W-1:0] byte_count_o;
  logic                       burst_end_o;
  logic                       stream_end_o;

  rle_packet_encoder_top i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .stream_last_i(stream_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_bytes_o  (out_bytes_o),
    .byte_count_o (byte_count_o),
    .burst_end_o  (burst_end_o),
    .stream_end_o (stream_end_o)
  );

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  // encoder state mirror
  logic [rle_pkg::BYTE_W-1:0] piece_val = '0;
  int unsigned                piece_len = 0;
  logic [rle_pkg::BYTE_W-1:0] raw_buf [rle_pkg::MAX_PACKET];
  int unsigned                raw_len   = 0;
  logic [rle_pkg::BYTE_W-1:0] step_bytes [$];
  packed_word_t               pending_words [$];

  // idle control and bookkeeping
  bit          src_gaps_on   = 1'b1;
  bit          sink_gaps_on  = 1'b1;
  int unsigned sink_hold_req = 0;
  int unsigned hold_taken    = 0;
  int unsigned hold_left     = 0;
  int unsigned burst_left    = 0;
  int unsigned err_cnt       = 0;
  bit          leftover      = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned streams_ended = 0;
  int unsigned words_checked = 0;
  int unsigned cycle_cnt     = 0;

  // append one byte to the output of the current step
  task automatic put_out_byte(input logic [rle_pkg::BYTE_W-1:0] b);
    step_bytes = {step_bytes, b};
  endtask

  // pending raw bytes go out as one packet, header len-1
  task automatic flush_raw_packet();
    logic [rle_pkg::BYTE_W-1:0] hdr;
    if (raw_len != 0) begin
      hdr = rle_pkg::BYTE_W'(raw_len - 1);
      put_out_byte(hdr);
      for (int i = 0; i < raw_len; i++) put_out_byte(raw_buf[i]);
      raw_len = 0;
    end
  endtask

  // long pieces become run packets, short ones join the raw packet
  task automatic close_piece();
    logic [rle_pkg::BYTE_W-1:0] hdr;
    if (piece_len >= rle_pkg::MIN_RUN) begin
      flush_raw_packet();
      hdr = rle_pkg::BYTE_W'(piece_len - 1);
      put_out_byte(rle_pkg::RUN_FLAG | hdr);
      put_out_byte(piece_val);
    end else if (piece_len != 0) begin
      if (raw_len + piece_len > rle_pkg::MAX_PACKET) flush_raw_packet();
      repeat (piece_len) begin
        raw_buf[raw_len] = piece_val;
        raw_len++;
      end
    end
    piece_len = 0;
  endtask

  // encode one accepted byte and queue the words it should produce
  task automatic encode_step(input logic [rle_pkg::BYTE_W-1:0] b, input logic last);
    packed_word_t               w;
    logic [rle_pkg::WORD_W-1:0] word;
    int unsigned                n_words;
    int unsigned                pos;
    step_bytes.delete();
    if (piece_len > 0 && b == piece_val && piece_len < rle_pkg::MAX_PACKET) begin
      piece_len++;
    end else begin
      close_piece();
      piece_val = b;
      piece_len = 1;
    end
    if (last) begin
      close_piece();
      flush_raw_packet();
    end
    n_words = (step_bytes.size() + rle_pkg::LANES - 1) / rle_pkg::LANES;
    for (int k = 0; k < n_words; k++) begin
      word    = '0;
      w.count = '0;
      for (int i = 0; i < rle_pkg::LANES; i++) begin
        pos = k * rle_pkg::LANES + i;
        if (pos < step_bytes.size()) begin
          word[rle_pkg::BYTE_W*i +: rle_pkg::BYTE_W] = step_bytes[pos];
          w.count++;
        end
      end
      w.word        = word;
      w.burst_end   = (k == n_words - 1);
      w.stream_end  = last && (k == n_words - 1);
      pending_words = {pending_words, w};
    end
  endtask

  // offer one byte, hold it until the transfer, then predict
  task automatic send_byte(input logic [rle_pkg::BYTE_W-1:0] b, input logic last);
    int unsigned gap;
    if (src_gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    stream_last_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_step(b, last);
    items_sent++;
    if (last) streams_ended++;
  endtask

  // sender pause until every expected word has come back or the drain limit is hit
  task automatic wait_drained(input int unsigned tail);
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_words.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (tail) @(posedge clk_i);
  endtask

  // field extremes, one-byte streams, short pieces, a run, quiet steps
  task automatic test_directed();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'haa, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h01, 1'b1);
    // raw byte flushed ahead of a run, then a three-byte raw packet ending the stream
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h7f, 1'b1);
  endtask

  // equal bytes past the longest piece: a full run then a new piece
  task automatic test_piece_full();
    logic [rle_pkg::BYTE_W-1:0] v;
    v = rle_pkg::BYTE_W'($urandom_range(0, 255));
    for (int i = 0; i < rle_pkg::MAX_PACKET + 1; i++) begin
      send_byte(v, i == rle_pkg::MAX_PACKET);
    end
  endtask

  // a full raw packet flushed when a short pair overflows it, then a raw
  // pair flushed ahead of a run
  task automatic test_full_raw_packets();
    logic [rle_pkg::BYTE_W-1:0] prev;
    logic [rle_pkg::BYTE_W-1:0] v;
    logic [rle_pkg::BYTE_W-1:0] r;
    prev = rle_pkg::BYTE_W'($urandom_range(0, 255));
    for (int i = 0; i < rle_pkg::MAX_PACKET; i++) begin
      prev = prev ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
      send_byte(prev, 1'b0);
    end
    v = prev ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
    send_byte(v, 1'b0);
    send_byte(v, 1'b0);
    r = v ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
    repeat (rle_pkg::MIN_RUN) send_byte(r, 1'b0);
    send_byte(r ^ rle_pkg::BYTE_W'($urandom_range(1, 255)), 1'b1);
  endtask

  // long sink hold while the source keeps offering result-heavy bytes
  task automatic test_sink_hold();
    logic [rle_pkg::BYTE_W-1:0] prev;
    logic [rle_pkg::BYTE_W-1:0] v;
    src_gaps_on   = 1'b0;
    sink_hold_req = SINK_HOLD;
    prev = rle_pkg::BYTE_W'($urandom_range(0, 255));
    for (int r = 0; r < 4; r++) begin
      v = prev ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
      repeat (rle_pkg::MIN_RUN) send_byte(v, 1'b0);
      prev = v ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
      send_byte(prev, r == 3);
    end
    src_gaps_on = 1'b1;
  endtask

  // mostly well-formed streams of pieces, some noise with stray ends
  task automatic test_random_streams(input int unsigned n_items, input bit gaps);
    int unsigned                sent;
    int unsigned                n_seg;
    int unsigned                seg_len;
    int unsigned                pick;
    logic [rle_pkg::BYTE_W-1:0] prev;
    logic [rle_pkg::BYTE_W-1:0] v;
    sent         = 0;
    prev         = rle_pkg::BYTE_W'($urandom_range(0, 255));
    sink_gaps_on = gaps;
    while (sent < n_items) begin
      src_gaps_on = gaps && ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) == 0) begin
        seg_len = $urandom_range(1, 12);
        repeat (seg_len) begin
          v = ($urandom_range(0, 2) == 0) ? prev
                                          : rle_pkg::BYTE_W'($urandom_range(0, 255));
          send_byte(v, $urandom_range(0, 7) == 0);
          prev = v;
          sent++;
        end
      end else begin
        n_seg = $urandom_range(1, 6);
        for (int s = 0; s < n_seg; s++) begin
          // now and then the same value again, so pieces merge
          v = ($urandom_range(0, 7) == 0) ? prev
                                          : prev ^ rle_pkg::BYTE_W'($urandom_range(1, 255));
          pick = $urandom_range(0, 39);
          if (pick < 24) seg_len = $urandom_range(1, 2);
          else if (pick < 39) seg_len = $urandom_range(rle_pkg::MIN_RUN, 8);
          else seg_len = $urandom_range(9, 40);
          for (int i = 0; i < seg_len; i++) send_byte(v, s == n_seg - 1 && i == seg_len - 1);
          prev = v;
          sent += seg_len;
        end
      end
    end
    send_byte(rle_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
    src_gaps_on = gaps;
  endtask

  // output side: check each transfer, then pick the next stall value
  always @(posedge clk_i) begin : sink
    packed_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_bytes %h byte_count %0d", out_bytes_o, byte_count_o);
        err_cnt++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_bytes_o !== want.word) begin
          $error("out_bytes: expected %h, got %h", want.word, out_bytes_o);
          err_cnt++;
        end
        if (byte_count_o !== want.count) begin
          $error("byte_count: expected %0d, got %0d", want.count, byte_count_o);
          err_cnt++;
        end
        if (burst_end_o !== want.burst_end) begin
          $error("burst_end: expected %b, got %b", want.burst_end, burst_end_o);
          err_cnt++;
        end
        if (stream_end_o !== want.stream_end) begin
          $error("stream_end: expected %b, got %b", want.stream_end, stream_end_o);
          err_cnt++;
        end
      end
    end
    if (sink_hold_req != hold_taken) begin
      hold_left  = sink_hold_req;
      hold_taken = sink_hold_req;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall_i <= 1'b1;
    end else if (sink_gaps_on && $urandom_range(0, 5) == 0) begin
      burst_left = $urandom_range(1, 8) - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // hard stop for a hung block
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    wait_drained(SETTLE);
    test_piece_full();
    wait_drained(SETTLE);
    test_full_raw_packets();
    wait_drained(SETTLE);
    test_sink_hold();
    wait_drained(SETTLE);
    test_random_streams(24, 1'b1);
    wait_drained(SETTLE);
    // closing stretch with no idling on either side
    test_random_streams(16, 1'b0);
    wait_drained(END_TAIL);
    if (pending_words.size() != 0) begin
      $error("words never delivered: %0d still expected", pending_words.size());
      leftover = 1'b1;
    end
    $display("run covered %0d bytes in %0d ended streams, %0d words checked",
             items_sent, streams_ended, words_checked);
    $display("incl. full runs, full and overflowing raw packets, long sink hold");
    if (err_cnt == 0 && !leftover) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== rle_packet_encoder_top.f =====
rtl/rle_pkg.sv
rtl/rle_ctrl.sv
rtl/rle_dpath.sv
rtl/rle_packet_encoder_top.sv
sim/tb_top.sv
